### rtl/trg_pkg.sv
// Shared widths, constants, CORDIC angle table and item side-band types.
package trg_pkg;

  localparam int XW = 20;
  localparam int ZW = 32;
  localparam int VW = 56;
  localparam int VZW = 34;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [XW-1:0] CORDIC_GAIN = 20'sd39797;
  localparam logic signed [33:0] FULL_E7 = 34'sd3600000000;
  localparam logic signed [33:0] HALF_E7 = 34'sd1800000000;
  localparam logic signed [33:0] QUARTER_E7 = 34'sd900000000;
  localparam logic signed [ZW-1:0] CD_TO_E7 = 32'sd100000;
  localparam logic [28:0] BRG_RECIP = 29'd351843720;
  localparam int BRG_SHIFT = 40;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 neg;
  } fold_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] hdg;
    logic [15:0] tcrs;
    logic [15:0] ocrs;
    logic [13:0] tspd;
    logic [13:0] ospd;
    logic [2:0]  neg;
    logic        zero;
  } sb1_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] hdg;
    logic [15:0] brg;
    logic [15:0] asp;
    logic [13:0] tspd;
    logic [13:0] ospd;
    logic [1:0]  neg;
  } sb2_t;

  function automatic logic [31:0] atan_e7(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd450000000;   1: r = 32'd265650512;   2: r = 32'd140362435;
      3: r = 32'd71250163;    4: r = 32'd35763344;    5: r = 32'd17899106;
      6: r = 32'd8951737;     7: r = 32'd4476142;     8: r = 32'd2238105;
      9: r = 32'd1119057;    10: r = 32'd559529;     11: r = 32'd279765;
      12: r = 32'd139882;    13: r = 32'd69941;      14: r = 32'd34971;
      15: r = 32'd17485;     16: r = 32'd8743;       17: r = 32'd4371;
      18: r = 32'd2186;      19: r = 32'd1093;       20: r = 32'd546;
      21: r = 32'd273;       22: r = 32'd137;        23: r = 32'd68;
      24: r = 32'd34;        25: r = 32'd17;         26: r = 32'd9;
      27: r = 32'd4;         28: r = 32'd2;          29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Reduce an angle in 1e-7 degree to [-90,90] with a sign flip flag.
  function automatic fold_t fold_e7(input logic signed [33:0] v);
    logic signed [33:0] a;
    fold_t f;
    a = v;
    f.neg = 1'b0;
    if (a < 0) a = a + FULL_E7;
    if (a < 0) a = a + FULL_E7;
    if (a >= FULL_E7) a = a - FULL_E7;
    if (a > HALF_E7) a = a - FULL_E7;
    if (a > QUARTER_E7) begin
      a = a - HALF_E7;
      f.neg = 1'b1;
    end else if (a < -QUARTER_E7) begin
      a = a + HALF_E7;
      f.neg = 1'b1;
    end
    f.z = ZW'(a);
    return f;
  endfunction

endpackage

### rtl/trg_if.sv
// Input and result channel interfaces.
interface trg_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        target_tag;
  logic signed [30:0] own_lat;
  logic signed [31:0] own_lon;
  logic [15:0]        own_course;
  logic [13:0]        own_speed;
  logic signed [30:0] tgt_lat;
  logic signed [31:0] tgt_lon;
  logic signed [17:0] tgt_heading;
  logic [15:0]        tgt_course;
  logic [13:0]        tgt_speed;

  modport source (output valid, target_tag, own_lat, own_lon, own_course, own_speed,
                  tgt_lat, tgt_lon, tgt_heading, tgt_course, tgt_speed, input ready);
  modport sink (input valid, target_tag, own_lat, own_lon, own_course, own_speed,
                tgt_lat, tgt_lon, tgt_heading, tgt_course, tgt_speed, output ready);
endinterface

interface trg_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        out_tag;
  logic [15:0]        bearing_to_target;
  logic [15:0]        heading_norm;
  logic [15:0]        aspect_angle;
  logic signed [15:0] closing_speed;

  modport source (output valid, out_tag, bearing_to_target, heading_norm, aspect_angle,
                  closing_speed, input ready);
  modport sink (input valid, out_tag, bearing_to_target, heading_norm, aspect_angle,
                closing_speed, output ready);
endinterface

### rtl/trg_rot_cell.sv
// One rotation-mode CORDIC step with its stage register.
module trg_rot_cell import trg_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  localparam logic signed [ZW-1:0] ANG = ZW'(atan_e7(STEP));

  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_r <= x_i - (y_i >>> STEP);
        y_r <= y_i + (x_i >>> STEP);
        z_r <= z_i - ANG;
      end else begin
        x_r <= x_i + (y_i >>> STEP);
        y_r <= y_i - (x_i >>> STEP);
        z_r <= z_i + ANG;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

### rtl/trg_vec_cell.sv
// One vectoring-mode CORDIC step with its stage register.
module trg_vec_cell import trg_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [VW-1:0]  x_i,
  input  logic signed [VW-1:0]  y_i,
  input  logic signed [VZW-1:0] z_i,
  output logic signed [VW-1:0]  x_o,
  output logic signed [VW-1:0]  y_o,
  output logic signed [VZW-1:0] z_o
);
  localparam logic signed [VZW-1:0] ANG = VZW'(atan_e7(STEP));

  logic signed [VW-1:0]  x_r, y_r;
  logic signed [VZW-1:0] z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_i >= 0) begin
        x_r <= x_i + (y_i >>> STEP);
        y_r <= y_i - (x_i >>> STEP);
        z_r <= z_i + ANG;
      end else begin
        x_r <= x_i - (y_i >>> STEP);
        y_r <= y_i + (x_i >>> STEP);
        z_r <= z_i - ANG;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

### rtl/target_relative_geometry.sv
// Top level: bearing, heading, aspect and line-of-sight speed pipeline.
//
//   channel | dir | handshake     | item
//   in_ch   | in  | valid / ready | own-ship and target pair
//   out_ch  | out | valid / ready | bearing, heading, aspect, closing speed
//
// One item per cycle while the result is not stalled; items pass three CORDIC
// cell rows plus ten arithmetic stages. The whole pipeline advances together
// whenever the output register is empty or taken, so a stalled result holds
// every stage. Reset clears the stage valid bits only and holds the input off.
module target_relative_geometry import trg_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  trg_in_if.sink    in_ch,
  trg_out_if.source out_ch
);
  localparam int N = CORDIC_STEPS;
  localparam int LAT = 3 * N + 10;
  localparam logic signed [VZW-1:0] FULL_V = 34'sd3600000000;

  logic adv;
  logic [LAT-1:0] v_r;

  assign adv = !v_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = rst_n && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_ch.valid};
    end
  end

  function automatic fold_t cfold(input logic [15:0] crs, input logic [15:0] brg);
    logic signed [16:0] d;
    fold_t f;
    d = $signed({1'b0, crs}) - $signed({1'b0, brg});
    f.neg = 1'b0;
    if (d < 0) d = d + 17'sd36000;
    if (d > 17'sd18000) d = d - 17'sd36000;
    if (d > 17'sd9000) begin
      d = d - 17'sd18000;
      f.neg = 1'b1;
    end else if (d < -17'sd9000) begin
      d = d + 17'sd18000;
      f.neg = 1'b1;
    end
    f.z = ZW'(d) * CD_TO_E7;
    return f;
  endfunction

  // input folding
  fold_t f_own, f_tgt, f_dl;
  sb1_t sb1_nxt, sb1_r;
  logic signed [ZW-1:0] z1_r [3];
  logic signed [33:0] dlon;
  logic [18:0] hu;

  assign dlon = 34'(in_ch.tgt_lon) - 34'(in_ch.own_lon);
  assign f_own = fold_e7(34'(in_ch.own_lat));
  assign f_tgt = fold_e7(34'(in_ch.tgt_lat));
  assign f_dl = fold_e7(dlon);

  always_comb begin
    hu = 19'(20'(in_ch.tgt_heading) + 20'sd144000);
    if (hu >= 19'd144000) hu = hu - 19'd144000;
    if (hu >= 19'd72000) hu = hu - 19'd72000;
    if (hu >= 19'd36000) hu = hu - 19'd36000;
    sb1_nxt.tag = in_ch.target_tag;
    sb1_nxt.hdg = 16'(hu);
    sb1_nxt.tcrs = (in_ch.tgt_course >= 16'd36000) ? in_ch.tgt_course - 16'd36000
                                                  : in_ch.tgt_course;
    sb1_nxt.ocrs = (in_ch.own_course >= 16'd36000) ? in_ch.own_course - 16'd36000
                                                  : in_ch.own_course;
    sb1_nxt.tspd = in_ch.tgt_speed;
    sb1_nxt.ospd = in_ch.own_speed;
    sb1_nxt.neg = {f_dl.neg, f_tgt.neg, f_own.neg};
    sb1_nxt.zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z1_r[0] <= f_own.z;
      z1_r[1] <= f_tgt.z;
      z1_r[2] <= f_dl.z;
      sb1_r <= sb1_nxt;
    end
  end

  // first rotation row: own latitude, target latitude, longitude difference
  logic signed [XW-1:0] ax [3][N+1];
  logic signed [XW-1:0] ay [3][N+1];
  logic signed [ZW-1:0] az [3][N+1];
  sb1_t sba_r [N];

  for (genvar l = 0; l < 3; l++) begin : g_rowa
    assign ax[l][0] = CORDIC_GAIN;
    assign ay[l][0] = '0;
    assign az[l][0] = z1_r[l];
    for (genvar i = 0; i < N; i++) begin : g_cell
      trg_rot_cell #(.STEP(i)) u_cell (
        .clk(clk), .en(adv),
        .x_i(ax[l][i]), .y_i(ay[l][i]), .z_i(az[l][i]),
        .x_o(ax[l][i+1]), .y_o(ay[l][i+1]), .z_o(az[l][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sba_r[0] <= sb1_r;
      for (int i = 1; i < N; i++) sba_r[i] <= sba_r[i-1];
    end
  end

  // products for the atan2 operands
  logic signed [XW-1:0] sa, ca, sb, cb, sd, cd;
  logic signed [39:0] p_sdcb_r, p_casb_r, p_sacb_r;
  logic signed [XW-1:0] cd_r;
  logic signed [59:0] p3;
  logic signed [VW-1:0] yv_r, xv_r;
  sb1_t sb2_r, sb3_r;

  assign ca = sba_r[N-1].neg[0] ? -ax[0][N] : ax[0][N];
  assign sa = sba_r[N-1].neg[0] ? -ay[0][N] : ay[0][N];
  assign cb = sba_r[N-1].neg[1] ? -ax[1][N] : ax[1][N];
  assign sb = sba_r[N-1].neg[1] ? -ay[1][N] : ay[1][N];
  assign cd = sba_r[N-1].neg[2] ? -ax[2][N] : ax[2][N];
  assign sd = sba_r[N-1].neg[2] ? -ay[2][N] : ay[2][N];
  assign p3 = p_sacb_r * cd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_sdcb_r <= sd * cb;
      p_casb_r <= ca * sb;
      p_sacb_r <= sa * cb;
      cd_r <= cd;
      sb2_r <= sba_r[N-1];
      yv_r <= VW'(p_sdcb_r) <<< 16;
      xv_r <= (VW'(p_casb_r) <<< 16) - VW'(p3);
      sb3_r <= sb2_r;
    end
  end

  // vectoring row
  logic signed [VW-1:0] vx [N+1];
  logic signed [VW-1:0] vy [N+1];
  logic signed [VZW-1:0] vz [N+1];
  logic signed [VW-1:0] vx0_r, vy0_r;
  logic signed [VZW-1:0] vz0_r;
  sb1_t sb4_nxt, sb4_r;
  sb1_t sbv_r [N];

  always_comb begin
    sb4_nxt = sb3_r;
    sb4_nxt.zero = (xv_r == '0) && (yv_r == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb4_r <= sb4_nxt;
      if (xv_r < 0) begin
        vx0_r <= -xv_r;
        vy0_r <= -yv_r;
        vz0_r <= VZW'(HALF_E7);
      end else begin
        vx0_r <= xv_r;
        vy0_r <= yv_r;
        vz0_r <= '0;
      end
    end
  end

  assign vx[0] = vx0_r;
  assign vy[0] = vy0_r;
  assign vz[0] = vz0_r;

  for (genvar i = 0; i < N; i++) begin : g_rowv
    trg_vec_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(adv),
      .x_i(vx[i]), .y_i(vy[i]), .z_i(vz[i]),
      .x_o(vx[i+1]), .y_o(vy[i+1]), .z_o(vz[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbv_r[0] <= sb4_r;
      for (int i = 1; i < N; i++) sbv_r[i] <= sbv_r[i-1];
    end
  end

  // bearing: wrap, round to centidegrees by reciprocal multiply
  logic signed [VZW-1:0] zf;
  logic [26:0] u_r, u6_r;
  logic [55:0] prod_r;
  logic [15:0] q0;
  logic [27:0] rr;
  logic [15:0] q;
  logic [15:0] brg7_r;
  sb1_t sb5_r, sb6_r, sb7_r;

  always_comb begin
    zf = sbv_r[N-1].zero ? '0 : vz[N];
    if (zf < 0) zf = zf + FULL_V;
    if (zf >= FULL_V) zf = zf - FULL_V;
  end

  assign q0 = prod_r[BRG_SHIFT+15:BRG_SHIFT];
  assign rr = 28'(u6_r) - 28'(q0) * 28'd3125;
  assign q = (rr >= 28'd3125) ? q0 + 16'd1 : q0;

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r <= 27'((zf + 34'sd50000) >>> 5);
      sb5_r <= sbv_r[N-1];
      prod_r <= 56'(u_r) * 56'(BRG_RECIP);
      u6_r <= u_r;
      sb6_r <= sb5_r;
      brg7_r <= (q >= 16'd36000) ? 16'd0 : q;
      sb7_r <= sb6_r;
    end
  end

  // aspect and course-minus-bearing angles
  logic signed [17:0] as_v;
  fold_t f_tc, f_oc;
  sb2_t sb8_nxt, sb8_r;
  logic signed [ZW-1:0] z8_r [2];

  assign f_tc = cfold(sb7_r.tcrs, brg7_r);
  assign f_oc = cfold(sb7_r.ocrs, brg7_r);

  always_comb begin
    as_v = $signed({2'b00, sb7_r.hdg}) - $signed({2'b00, brg7_r}) + 18'sd18000;
    if (as_v < 0) as_v = as_v + 18'sd36000;
    else if (as_v >= 18'sd36000) as_v = as_v - 18'sd36000;
    sb8_nxt.tag = sb7_r.tag;
    sb8_nxt.hdg = sb7_r.hdg;
    sb8_nxt.brg = brg7_r;
    sb8_nxt.asp = 16'(as_v);
    sb8_nxt.tspd = sb7_r.tspd;
    sb8_nxt.ospd = sb7_r.ospd;
    sb8_nxt.neg = {f_oc.neg, f_tc.neg};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z8_r[0] <= f_tc.z;
      z8_r[1] <= f_oc.z;
      sb8_r <= sb8_nxt;
    end
  end

  // second rotation row: target course, own course
  logic signed [XW-1:0] cx [2][N+1];
  logic signed [XW-1:0] cy [2][N+1];
  logic signed [ZW-1:0] cz [2][N+1];
  sb2_t sbc_r [N];

  for (genvar l = 0; l < 2; l++) begin : g_rowc
    assign cx[l][0] = CORDIC_GAIN;
    assign cy[l][0] = '0;
    assign cz[l][0] = z8_r[l];
    for (genvar i = 0; i < N; i++) begin : g_cell
      trg_rot_cell #(.STEP(i)) u_cell (
        .clk(clk), .en(adv),
        .x_i(cx[l][i]), .y_i(cy[l][i]), .z_i(cz[l][i]),
        .x_o(cx[l][i+1]), .y_o(cy[l][i+1]), .z_o(cz[l][i+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sbc_r[0] <= sb8_r;
      for (int i = 1; i < N; i++) sbc_r[i] <= sbc_r[i-1];
    end
  end

  // speed products, round and saturate
  logic signed [XW-1:0] ct, co;
  logic signed [34:0] pt_r, po_r;
  sb2_t sb9_r;
  logic signed [35:0] sm;
  logic signed [19:0] rl;
  logic signed [15:0] rel;
  logic [15:0] o_tag_r, o_brg_r, o_hdg_r, o_asp_r;
  logic signed [15:0] o_rel_r;

  assign ct = sbc_r[N-1].neg[0] ? -cx[0][N] : cx[0][N];
  assign co = sbc_r[N-1].neg[1] ? -cx[1][N] : cx[1][N];

  always_comb begin
    sm = 36'(pt_r) - 36'(po_r) + 36'sd32768;
    rl = 20'(sm >>> 16);
    if (rl > 20'sd20000) rel = 16'sd20000;
    else if (rl < -20'sd20000) rel = -16'sd20000;
    else rel = 16'(rl);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt_r <= $signed({1'b0, sbc_r[N-1].tspd}) * ct;
      po_r <= $signed({1'b0, sbc_r[N-1].ospd}) * co;
      sb9_r <= sbc_r[N-1];
      o_tag_r <= sb9_r.tag;
      o_brg_r <= sb9_r.brg;
      o_hdg_r <= sb9_r.hdg;
      o_asp_r <= sb9_r.asp;
      o_rel_r <= rel;
    end
  end

  assign out_ch.valid = v_r[LAT-1];
  assign out_ch.out_tag = o_tag_r;
  assign out_ch.bearing_to_target = o_brg_r;
  assign out_ch.heading_norm = o_hdg_r;
  assign out_ch.aspect_angle = o_asp_r;
  assign out_ch.closing_speed = o_rel_r;

  a_brg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.bearing_to_target < 16'd36000)
    else $error("bearing out of range");

  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.aspect_angle < 16'd36000) && (out_ch.heading_norm < 16'd36000))
    else $error("aspect or heading out of range");

  a_spd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.closing_speed <= 16'sd20000) &&
                     (out_ch.closing_speed >= -16'sd20000))
    else $error("closing speed not saturated");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("item taken while result stalled");

endmodule
